// ===== sv/bps_pkg.sv =====
// ----------------------------------------------------------------------------
// bps_pkg
// Shared types and constants for the byte pattern search unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bps_pkg;

    localparam int MAX_PATTERN_DEF   = 32;
    localparam int POSITION_BITS_DEF = 32;

    localparam int BYTE_W      = 8;
    localparam int OFFSET_W    = 48;
    localparam int PAT_BYTES   = 32;
    localparam int PAT_IDX_W   = 5;
    localparam int PAT_W       = PAT_BYTES * BYTE_W;
    localparam int RAW_LEN_W   = 6;

    localparam int APB_DATA_W  = 64;
    localparam int APB_ADDR_W  = 6;
    localparam int REG_IDX_W   = 3;
    localparam int REG_LSB     = 3;
    localparam int PAT_REGS    = 4;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_LENGTH = 3'd0,
        REG_PAT_0  = 3'd1,
        REG_PAT_1  = 3'd2,
        REG_PAT_2  = 3'd3,
        REG_PAT_3  = 3'd4
    } t_reg_idx;

    typedef logic [PAT_BYTES-1:0][BYTE_W-1:0] t_pattern;

    // Control that every cell of the window sees in the same cycle.
    typedef struct packed {
        logic shift;
        logic clear;
    } t_shift_ctl;

endpackage

`default_nettype wire

// ===== sv/bps_cfg.sv =====
// ----------------------------------------------------------------------------
// bps_cfg
// APB register file holding the pattern length and the 32 pattern bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module bps_cfg (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [bps_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [bps_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [bps_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                   pready,
    output logic      [bps_pkg::RAW_LEN_W-1:0]     o_length_raw,
    output bps_pkg::t_pattern                      o_pattern
);

    logic [bps_pkg::RAW_LEN_W-1:0]  r_length;
    logic [bps_pkg::APB_DATA_W-1:0] r_pat [bps_pkg::PAT_REGS];
    logic [bps_pkg::REG_IDX_W-1:0]  w_idx;
    logic                           w_wr;

    assign w_idx  = paddr[bps_pkg::APB_ADDR_W-1:bps_pkg::REG_LSB];
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length <= bps_pkg::RAW_LEN_W'(1);
            for (int i = 0; i < bps_pkg::PAT_REGS; i++) begin
                r_pat[i] <= '0;
            end
        end else if (w_wr) begin
            unique case (w_idx)
                bps_pkg::REG_LENGTH: r_length <= pwdata[bps_pkg::RAW_LEN_W-1:0];
                bps_pkg::REG_PAT_0:  r_pat[0] <= pwdata;
                bps_pkg::REG_PAT_1:  r_pat[1] <= pwdata;
                bps_pkg::REG_PAT_2:  r_pat[2] <= pwdata;
                bps_pkg::REG_PAT_3:  r_pat[3] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            bps_pkg::REG_LENGTH: prdata = bps_pkg::APB_DATA_W'(r_length);
            bps_pkg::REG_PAT_0:  prdata = r_pat[0];
            bps_pkg::REG_PAT_1:  prdata = r_pat[1];
            bps_pkg::REG_PAT_2:  prdata = r_pat[2];
            bps_pkg::REG_PAT_3:  prdata = r_pat[3];
            default:             prdata = '0;
        endcase
    end

    assign o_length_raw = r_length;

    always_comb begin
        for (int i = 0; i < bps_pkg::PAT_REGS; i++) begin
            for (int k = 0; k < 8; k++) begin
                o_pattern[i*8 + k] = r_pat[i][k*bps_pkg::BYTE_W +: bps_pkg::BYTE_W];
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/bps_cell.sv =====
// ----------------------------------------------------------------------------
// bps_cell
// One position of the shift window: a byte, its fill bit and the pattern
// byte it is compared against.
// ----------------------------------------------------------------------------
`default_nettype none

module bps_cell #(
    parameter int CELL_INDEX = 0,
    parameter int LEN_W      = 6
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire bps_pkg::t_shift_ctl           i_ctl,
    input  wire logic [bps_pkg::BYTE_W-1:0]    i_byte,
    input  wire logic                          i_valid,
    input  wire bps_pkg::t_pattern             i_pattern,
    input  wire logic [LEN_W-1:0]              i_length,
    output logic      [bps_pkg::BYTE_W-1:0]    o_byte,
    output logic                               o_valid,
    output logic                               o_match
);

    localparam int IDX_W = (LEN_W > bps_pkg::RAW_LEN_W) ? LEN_W : bps_pkg::RAW_LEN_W;

    logic [bps_pkg::BYTE_W-1:0] r_byte;
    logic                       r_valid;
    logic [bps_pkg::BYTE_W-1:0] r_cmp;
    logic                       r_en;
    logic [bps_pkg::BYTE_W-1:0] n_cmp;
    logic                       n_en;
    logic                       n_valid;
    logic [IDX_W-1:0]           w_len;
    logic [IDX_W-1:0]           w_idx;

    // The cell at window index j holds the byte that arrived j transactions
    // ago, so it must equal pattern byte length-1-j.
    always_comb begin
        w_len = IDX_W'(i_length);
        n_en  = w_len > IDX_W'(CELL_INDEX);
        w_idx = w_len - IDX_W'(CELL_INDEX) - IDX_W'(1);
        if (n_en && (w_idx < IDX_W'(bps_pkg::PAT_BYTES))) begin
            n_cmp = i_pattern[w_idx[bps_pkg::PAT_IDX_W-1:0]];
        end else begin
            n_cmp = '0;
        end
    end

    assign n_valid = (CELL_INDEX == 0) ? 1'b1 : (i_valid & ~i_ctl.clear);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.shift) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_byte <= i_byte;
        end
        r_cmp <= n_cmp;
        r_en  <= n_en;
    end

    assign o_byte  = r_byte;
    assign o_valid = r_valid;
    assign o_match = ~r_en | (r_valid & (r_byte == r_cmp));

endmodule

`default_nettype wire

// ===== sv/byte_pattern_search_unit.sv =====
// ----------------------------------------------------------------------------
// byte_pattern_search_unit
// Streams buffer bytes through a chain of window cells and reports the
// absolute start offset of every occurrence of the configured pattern.
// ----------------------------------------------------------------------------
// The unit takes one byte per clock cycle while the input is not stalled;
// each byte shifts the window chain by one cell, and every cell compares its
// byte in parallel, so the rate is set by the shift of the chain. Accepting
// the byte that completes an occurrence shifts it into the window and
// registers its start position and buffer base in the compare stage; the
// output register then takes the compare result together with the addition
// of the buffer base, saturated at the 48-bit maximum, once it is free.
// The input stalls only while a match offset waits in the output register
// and the compare stage already holds a byte. Overlapping occurrences are
// all reported, and a byte flagged as buffer start empties the window first.
// Pattern registers should be written while no transaction is in flight;
// they act from the next byte on.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_pattern_search_unit #(
    parameter int MAX_PATTERN   = bps_pkg::MAX_PATTERN_DEF,
    parameter int POSITION_BITS = bps_pkg::POSITION_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [bps_pkg::BYTE_W-1:0]        i_data_byte,
    input  wire logic                              i_buffer_start,
    input  wire logic [bps_pkg::OFFSET_W-1:0]      i_base_offset,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic      [bps_pkg::OFFSET_W-1:0]      o_match_offset,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [bps_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [bps_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [bps_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                   pready
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int SUM_W = bps_pkg::OFFSET_W + 1;

    logic [bps_pkg::RAW_LEN_W-1:0] w_length_raw;
    bps_pkg::t_pattern             w_pattern;
    logic [LEN_W-1:0]              w_len;

    logic [POSITION_BITS-1:0]      r_pos;
    logic [POSITION_BITS-1:0]      n_pos;
    logic [POSITION_BITS-1:0]      w_pos_cur;
    logic [POSITION_BITS-1:0]      w_len_m1;
    logic [POSITION_BITS-1:0]      w_start;
    logic [bps_pkg::OFFSET_W-1:0]  r_base;
    logic [bps_pkg::OFFSET_W-1:0]  w_base_cur;

    logic                          r_s1_valid;
    logic [POSITION_BITS-1:0]      r_s1_start;
    logic [bps_pkg::OFFSET_W-1:0]  r_s1_base;

    logic                          r_out_valid;
    logic [bps_pkg::OFFSET_W-1:0]  r_out_offset;

    logic                          w_in_acc;
    logic                          w_out_free;
    logic                          w_hit;
    logic [SUM_W-1:0]              w_sum;
    logic [bps_pkg::OFFSET_W-1:0]  w_sat;

    bps_pkg::t_shift_ctl           w_ctl;
    logic [bps_pkg::BYTE_W-1:0]    w_cell_byte  [MAX_PATTERN];
    logic                          w_cell_valid [MAX_PATTERN];
    logic [MAX_PATTERN-1:0]        w_cell_match;

    bps_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_length_raw (w_length_raw),
        .o_pattern    (w_pattern)
    );

    // A length of zero acts as one; a length beyond the window acts as the
    // full window.
    always_comb begin
        if (w_length_raw == '0) begin
            w_len = LEN_W'(1);
        end else if ({1'b0, w_length_raw} > (bps_pkg::RAW_LEN_W + 1)'(MAX_PATTERN)) begin
            w_len = LEN_W'(MAX_PATTERN);
        end else begin
            w_len = LEN_W'(w_length_raw);
        end
    end

    // Handshake: the window can only shift when the compare stage moves on.
    assign w_out_free = ~r_out_valid | ~i_out_stall;
    assign o_in_stall = r_s1_valid & ~w_out_free;
    assign w_in_acc   = i_in_valid & ~o_in_stall;

    assign w_ctl.shift = w_in_acc;
    assign w_ctl.clear = i_buffer_start;

    // Position bookkeeping for the accepted byte.
    always_comb begin
        w_pos_cur  = i_buffer_start ? '0 : r_pos;
        w_base_cur = i_buffer_start ? i_base_offset : r_base;
        n_pos      = (w_pos_cur == {POSITION_BITS{1'b1}}) ? w_pos_cur
                                                          : w_pos_cur + POSITION_BITS'(1);
        w_len_m1   = POSITION_BITS'(w_len) - POSITION_BITS'(1);
        w_start    = (w_pos_cur >= w_len_m1) ? (w_pos_cur - w_len_m1) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_base <= '0;
        end else if (w_in_acc) begin
            r_pos  <= n_pos;
            r_base <= w_base_cur;
        end
    end

    genvar g;
    generate
        for (g = 0; g < MAX_PATTERN; g++) begin : g_cell
            if (g == 0) begin : g_head
                bps_cell #(
                    .CELL_INDEX (g),
                    .LEN_W      (LEN_W)
                ) u_cell (
                    .i_clk     (i_clk),
                    .i_rst_n   (i_rst_n),
                    .i_ctl     (w_ctl),
                    .i_byte    (i_data_byte),
                    .i_valid   (1'b1),
                    .i_pattern (w_pattern),
                    .i_length  (w_len),
                    .o_byte    (w_cell_byte[g]),
                    .o_valid   (w_cell_valid[g]),
                    .o_match   (w_cell_match[g])
                );
            end else begin : g_body
                bps_cell #(
                    .CELL_INDEX (g),
                    .LEN_W      (LEN_W)
                ) u_cell (
                    .i_clk     (i_clk),
                    .i_rst_n   (i_rst_n),
                    .i_ctl     (w_ctl),
                    .i_byte    (w_cell_byte[g-1]),
                    .i_valid   (w_cell_valid[g-1]),
                    .i_pattern (w_pattern),
                    .i_length  (w_len),
                    .o_byte    (w_cell_byte[g]),
                    .o_valid   (w_cell_valid[g]),
                    .o_match   (w_cell_match[g])
                );
            end
        end
    endgenerate

    // Compare stage: the window now holds the byte of this transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (w_out_free) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_start <= w_start;
            r_s1_base  <= w_base_cur;
        end
    end

    assign w_hit = &w_cell_match;
    assign w_sum = {1'b0, r_s1_base} + SUM_W'(r_s1_start);
    assign w_sat = w_sum[bps_pkg::OFFSET_W] ? {bps_pkg::OFFSET_W{1'b1}}
                                            : w_sum[bps_pkg::OFFSET_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_s1_valid & w_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && r_s1_valid && w_hit) begin
            r_out_offset <= w_sat;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_match_offset = r_out_offset;

endmodule

`default_nettype wire

// ===== dv/byte_pattern_search_unit_tb.sv =====
// ----------------------------------------------------------------------------
// byte_pattern_search_unit_tb
// Self-checking testbench for the byte pattern search unit. Buffers with
// embedded, overlapping and broken copies of the configured pattern are
// streamed through the unit. A behavioral copy of the search predicts every
// match offset, and the output monitor compares each offset in order.
// Pattern settings change between phases, and the idle and stall rates of
// both channels vary from phase to phase.
// ----------------------------------------------------------------------------
module byte_pattern_search_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BYTE_W            = bps_pkg::BYTE_W;
    localparam int OFFSET_W          = bps_pkg::OFFSET_W;
    localparam int PAT_BYTES         = bps_pkg::PAT_BYTES;
    localparam int PAT_W             = bps_pkg::PAT_W;
    localparam int RAW_LEN_W         = bps_pkg::RAW_LEN_W;
    localparam int APB_DATA_W        = bps_pkg::APB_DATA_W;
    localparam int APB_ADDR_W        = bps_pkg::APB_ADDR_W;
    localparam int REG_LSB           = bps_pkg::REG_LSB;
    localparam int MAX_PATTERN_DEF   = bps_pkg::MAX_PATTERN_DEF;
    localparam int POSITION_BITS_DEF = bps_pkg::POSITION_BITS_DEF;

    localparam int          HALF_PERIOD   = 6;
    localparam logic [47:0] OFFSET_MAX    = {OFFSET_W{1'b1}};
    localparam int          SETTLE_CYCLES = 8;
    localparam int          HOLD_CYCLES   = 240;
    localparam int          NUM_PHASES    = 12;
    localparam int          PHASE_BYTES   = 150;

    typedef struct packed {
        logic [BYTE_W-1:0]   data;
        logic                start;
        logic [OFFSET_W-1:0] base;
    } t_scan_byte;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_in_valid     = 1'b0;
    logic                  o_in_stall;
    logic [BYTE_W-1:0]     i_data_byte    = '0;
    logic                  i_buffer_start = 1'b0;
    logic [OFFSET_W-1:0]   i_base_offset  = '0;
    logic                  o_out_valid;
    logic                  i_out_stall    = 1'b0;
    logic [OFFSET_W-1:0]   o_match_offset;
    logic                  psel           = 1'b0;
    logic                  penable        = 1'b0;
    logic                  pwrite         = 1'b0;
    logic [APB_ADDR_W-1:0] paddr          = '0;
    logic [APB_DATA_W-1:0] pwdata         = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Search state and register mirror of the expected behavior.
    logic [BYTE_W-1:0]            win_bytes [MAX_PATTERN_DEF];
    int unsigned                  win_fill;
    logic [POSITION_BITS_DEF-1:0] buf_pos;
    logic [OFFSET_W-1:0]          buf_base;
    logic [RAW_LEN_W-1:0]         len_cfg;
    logic [BYTE_W-1:0]            pat_cfg [PAT_BYTES];

    t_scan_byte          pending_bytes [$];
    logic [OFFSET_W-1:0] expected_offsets [$];
    t_scan_byte          next_byte;
    logic [OFFSET_W-1:0] want_offset;

    int unsigned send_gap_pct    = 0;
    int unsigned stall_pct       = 0;
    int unsigned hold_left       = 0;
    logic        hold_kick       = 1'b0;
    int unsigned bytes_sent      = 0;
    int unsigned offsets_checked = 0;
    int unsigned mismatch_count  = 0;

    byte_pattern_search_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_buffer_start (i_buffer_start),
        .i_base_offset  (i_base_offset),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_match_offset (o_match_offset),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic int unsigned effective_len(logic [RAW_LEN_W-1:0] raw);
        if (raw == 0) return 1;
        if (raw > MAX_PATTERN_DEF) return MAX_PATTERN_DEF;
        return int'(raw);
    endfunction

    // Shifts one byte into the window and queues the start offset of the
    // occurrence that ends with it, if there is one.
    function automatic void scan_and_match(t_scan_byte b);
        int unsigned                  eff;
        int unsigned                  k;
        logic [POSITION_BITS_DEF-1:0] here;
        logic [OFFSET_W-1:0]          first;
        logic [OFFSET_W:0]            sum;
        bit                           hit;
        if (b.start) begin
            buf_base = b.base;
            buf_pos  = '0;
            win_fill = 0;
            foreach (win_bytes[i]) win_bytes[i] = '0;
        end
        for (k = MAX_PATTERN_DEF - 1; k > 0; k--) win_bytes[k] = win_bytes[k-1];
        win_bytes[0] = b.data;
        if (win_fill < MAX_PATTERN_DEF) win_fill++;
        here = buf_pos;
        if (buf_pos != '1) buf_pos++;
        eff = effective_len(len_cfg);
        if (win_fill < eff) return;
        hit = 1'b1;
        for (k = 0; k < eff; k++) begin
            if (win_bytes[eff-1-k] != pat_cfg[k]) hit = 1'b0;
        end
        if (!hit) return;
        first = (here >= eff - 1) ? OFFSET_W'(here - (eff - 1)) : '0;
        sum   = {1'b0, buf_base} + {1'b0, first};
        expected_offsets.insert(expected_offsets.size(),
                                sum[OFFSET_W] ? OFFSET_MAX : sum[OFFSET_W-1:0]);
    endfunction

    task automatic flag_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= 100) $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    // Input driver: holds a stalled transaction, otherwise offers the next
    // pending byte unless the sender idles this cycle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                scan_and_match('{data: i_data_byte, start: i_buffer_start, base: i_base_offset});
                bytes_sent++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
                    next_byte = pending_bytes.pop_front();
                    i_in_valid     <= 1'b1;
                    i_data_byte    <= next_byte.data;
                    i_buffer_start <= next_byte.start;
                    i_base_offset  <= next_byte.base;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Long output hold-off, counted here so the driver keeps offering bytes.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_kick) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Output monitor.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_offsets.size() == 0) begin
                    flag_mismatch($sformatf("unexpected match offset %h", o_match_offset));
                end else begin
                    want_offset = expected_offsets.pop_front();
                    offsets_checked++;
                    if (o_match_offset !== want_offset) begin
                        flag_mismatch($sformatf("match_offset %h, expected %h",
                                                o_match_offset, want_offset));
                    end
                end
            end
            i_out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic reg_write(bps_pkg::t_reg_idx idx, logic [APB_DATA_W-1:0] val);
        int unsigned k;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(int'(idx) << REG_LSB);
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            bps_pkg::REG_LENGTH: begin
                len_cfg = val[RAW_LEN_W-1:0];
            end
            default: begin
                for (k = 0; k < 8; k++) pat_cfg[(int'(idx) - 1) * 8 + k] = val[8*k +: 8];
            end
        endcase
    endtask

    // Waits until every byte is taken and every expected offset has arrived,
    // then lets the pipeline drain of bytes that produce no match.
    task automatic wait_quiet();
        do @(negedge i_clk);
        while (pending_bytes.size() != 0 || i_in_valid || expected_offsets.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic queue_byte(logic [BYTE_W-1:0] data, logic start, logic [OFFSET_W-1:0] base);
        pending_bytes.insert(pending_bytes.size(), '{data: data, start: start, base: base});
    endtask

    // One buffer: noise drawn mostly from the pattern's own bytes, with full
    // and truncated copies of the pattern written over it.
    task automatic queue_buffer(logic [PAT_W-1:0] pat, int unsigned eff, bit fresh,
                                int unsigned n);
        logic [BYTE_W-1:0]   body [];
        logic [OFFSET_W-1:0] base;
        int unsigned         i;
        int unsigned         k;
        int unsigned         c;
        int unsigned         at;
        int unsigned         copies;
        body = new[n];
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) == 0) body[i] = BYTE_W'($urandom);
            else body[i] = pat[8*$urandom_range(0, eff - 1) +: 8];
        end
        copies = $urandom_range(0, n / eff + 1);
        for (c = 0; c < copies; c++) begin
            at = $urandom_range(0, n - 1);
            for (k = 0; k < eff && at + k < n; k++) body[at+k] = pat[8*k +: 8];
        end
        case ($urandom_range(0, 3))
            0: base = '0;
            1: base = OFFSET_MAX - OFFSET_W'($urandom_range(0, 2 * eff + 8));
            default: base = OFFSET_W'({$urandom, $urandom});
        endcase
        for (i = 0; i < n; i++) begin
            queue_byte(body[i], fresh && i == 0,
                       (i == 0) ? base : OFFSET_W'({$urandom, $urandom}));
        end
    endtask

    initial begin : stimulus
        int unsigned       raw_lens [NUM_PHASES];
        logic [PAT_W-1:0]  pat;
        logic [BYTE_W-1:0] seed [3];
        int unsigned       p;
        int unsigned       k;
        int unsigned       eff;
        int unsigned       period;
        int unsigned       phase_start;
        int unsigned       n;
        bit                fresh;

        raw_lens = '{1, 32, 0, 33, 63, 2, 3, 5, 8, 16, 31, 4};
        foreach (win_bytes[i]) win_bytes[i] = '0;
        foreach (pat_cfg[i]) pat_cfg[i] = '0;
        win_fill = 0;
        buf_pos  = '0;
        buf_base = '0;
        len_cfg  = RAW_LEN_W'(1);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Bytes before any buffer start, matched against the reset pattern.
        queue_byte(8'h00, 1'b0, OFFSET_W'({$urandom, $urandom}));
        queue_byte(8'hFF, 1'b0, OFFSET_MAX);
        queue_byte(8'h00, 1'b0, '0);
        wait_quiet();

        // A length of zero acts as one; offsets saturate at the top.
        reg_write(bps_pkg::REG_LENGTH, '0);
        reg_write(bps_pkg::REG_PAT_0, {56'($urandom), 8'hFF});
        queue_byte(8'hFF, 1'b1, OFFSET_MAX);
        queue_byte(8'hFF, 1'b0, '0);
        queue_byte(8'h00, 1'b0, OFFSET_MAX);
        queue_byte(8'hFF, 1'b1, '0);
        wait_quiet();

        // Overlapping occurrences close to the top of the offset range.
        reg_write(bps_pkg::REG_LENGTH, 64'd3);
        reg_write(bps_pkg::REG_PAT_0, 64'h0000_0000_00FF_00FF);
        queue_byte(8'hFF, 1'b1, OFFSET_MAX - 5);
        for (k = 0; k < 6; k++) queue_byte((k % 2 == 0) ? 8'h00 : 8'hFF, 1'b0, '0);
        wait_quiet();

        // Shorter length mid-buffer sees the bytes already in the window.
        reg_write(bps_pkg::REG_LENGTH, 64'd2);
        queue_byte(8'h00, 1'b0, OFFSET_MAX);
        queue_byte(8'hFF, 1'b0, '0);
        queue_byte(8'h00, 1'b0, '0);
        wait_quiet();

        for (p = 0; p < NUM_PHASES; p++) begin
            if (p == NUM_PHASES - 1) raw_lens[p] = $urandom_range(0, 63);
            period = $urandom_range(1, 3);
            foreach (seed[i]) seed[i] = BYTE_W'($urandom);
            for (k = 0; k < PAT_BYTES; k++) begin
                if (p == 4) pat[8*k +: 8] = 8'hFF;
                else if (p == 6) pat[8*k +: 8] = 8'h00;
                else if (p % 3 == 0) pat[8*k +: 8] = seed[k % period];
                else pat[8*k +: 8] = BYTE_W'($urandom);
            end
            reg_write(bps_pkg::REG_LENGTH, APB_DATA_W'(raw_lens[p]));
            reg_write(bps_pkg::REG_PAT_0, pat[63:0]);
            reg_write(bps_pkg::REG_PAT_1, pat[127:64]);
            reg_write(bps_pkg::REG_PAT_2, pat[191:128]);
            reg_write(bps_pkg::REG_PAT_3, pat[255:192]);
            eff = effective_len(RAW_LEN_W'(raw_lens[p]));

            @(negedge i_clk);
            case (p % 4)
                0: begin send_gap_pct = 0;  stall_pct = 0;  end
                1: begin send_gap_pct = 66; stall_pct = 0;  end
                2: begin send_gap_pct = 0;  stall_pct = 66; end
                default: begin send_gap_pct = 31; stall_pct = 31; end
            endcase

            // A random choice per phase decides whether it continues the previous buffer under new settings.
            fresh       = $urandom_range(0, 1);
            phase_start = pending_bytes.size();
            while (pending_bytes.size() - phase_start < PHASE_BYTES) begin
                if ($urandom_range(0, 7) == 0) n = $urandom_range(1, 3 * eff + 20);
                else n = $urandom_range(1, 2 * eff + 6);
                queue_buffer(pat, eff, fresh, n);
                fresh = 1'b1;
            end

            if (p == 4) begin
                @(posedge i_clk) hold_kick <= 1'b1;
                @(posedge i_clk) hold_kick <= 1'b0;
            end
            wait_quiet();
        end

        send_gap_pct = 0;
        stall_pct    = 0;
        wait_quiet();
        repeat (20) @(negedge i_clk);

        $display("Streamed %0d bytes over %0d pattern settings; %0d match offsets compared.",
                 bytes_sent, NUM_PHASES + 4, offsets_checked);
        $display("Included clamped lengths, saturated offsets, reconfiguration within a buffer",
                 " and a long output hold-off.");
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
